// ===== hw/rtl/fcba_pkg.sv =====
// Shared types and codes of the chained block allocator.
package fcba_pkg;

	// block table size, fixed by the 7-bit block fields
	localparam int NUM_BLOCKS = 128;

	// command codes
	localparam logic [2:0] CMD_CREATE = 3'd0;
	localparam logic [2:0] CMD_APPEND = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_NEXT   = 3'd3;
	localparam logic [2:0] CMD_CHECK  = 3'd4;
	localparam logic [2:0] CMD_REMOVE = 3'd5;
	localparam logic [2:0] CMD_SPARE0 = 3'd6;
	localparam logic [2:0] CMD_SPARE1 = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXISTS    = 3'd1;
	localparam logic [2:0] ST_DIR_FULL  = 3'd2;
	localparam logic [2:0] ST_NO_FREE   = 3'd3;
	localparam logic [2:0] ST_NO_FILE   = 3'd4;
	localparam logic [2:0] ST_NOT_IN    = 3'd5;
	localparam logic [2:0] ST_NOT_EMPTY = 3'd6;

	// classified command handed from the front to the back
	typedef struct packed {
		logic [2:0]  cmd;
		logic [63:0] file_name;
		logic [6:0]  block_number;
		logic        blk_ok;
	} item_t;

endpackage

// ===== hw/rtl/fcba_front.sv =====
// Front end: accepts commands, classifies the block operand, queues two deep.
module fcba_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [2:0]      cmd,
	input  logic [63:0]     file_name,
	input  logic [6:0]      block_number,
	output logic            item_valid,
	input  logic            item_ready,
	output fcba_pkg::item_t item
);

	localparam int NUM_BLOCKS = fcba_pkg::NUM_BLOCKS;

	fcba_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            do_push;
	logic            do_pop;
	fcba_pkg::item_t new_item;

	// classify: flag a block operand that is not zero and lies inside the block table
	always_comb begin
		new_item.cmd          = cmd;
		new_item.file_name    = file_name;
		new_item.block_number = block_number;
		new_item.blk_ok       = (block_number != 7'd0) && (int'(block_number) < NUM_BLOCKS);
	end

	assign full       = (count_q == 2'd2);
	assign item_valid = (count_q != 2'd0);
	assign item       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = item_valid && item_ready;

	// advance pointers and count on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

	// hold queued payload
	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= new_item;
	end

endmodule

// ===== hw/rtl/fcba_back.sv =====
// Back end: directory scan, block table walks and the result register.
module fcba_back #(
	parameter int ROOT_ENTRIES = 10,
	parameter int TABLE_BLOCKS = 7
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  fcba_pkg::item_t item,
	output logic            empty,
	input  logic            pop,
	output logic [2:0]      status,
	output logic [6:0]      block_out
);

	localparam int NUM_BLOCKS = fcba_pkg::NUM_BLOCKS;
	localparam int AW = $clog2(NUM_BLOCKS);
	localparam int LW = AW + 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);
	localparam int DW = (ROOT_ENTRIES > 1) ? $clog2(ROOT_ENTRIES) : 1;
	localparam int FIRST_DATA = 2 + TABLE_BLOCKS;

	localparam logic [4:0] S_INIT  = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_DRD   = 5'd2;
	localparam logic [4:0] S_DCHK  = 5'd3;
	localparam logic [4:0] S_DISP  = 5'd4;
	localparam logic [4:0] S_RD    = 5'd5;
	localparam logic [4:0] S_HCHK  = 5'd6;
	localparam logic [4:0] S_H2CHK = 5'd7;
	localparam logic [4:0] S_AW0   = 5'd8;
	localparam logic [4:0] S_AWH   = 5'd9;
	localparam logic [4:0] S_WCHK  = 5'd10;
	localparam logic [4:0] S_AWT   = 5'd11;
	localparam logic [4:0] S_OSTEP = 5'd12;
	localparam logic [4:0] S_OCHK  = 5'd13;
	localparam logic [4:0] S_LCHK  = 5'd14;
	localparam logic [4:0] S_DLNK  = 5'd15;
	localparam logic [4:0] S_D0CHK = 5'd16;
	localparam logic [4:0] S_DHEAD = 5'd17;

	// block table and directory storage
	logic [LW-1:0] tbl_mem [NUM_BLOCKS];
	logic [63:0]   dname_mem [ROOT_ENTRIES];
	logic [AW-1:0] dfirst_mem [ROOT_ENTRIES];
	logic [ROOT_ENTRIES-1:0] dvalid_q;

	logic [4:0]    state_q;
	logic [4:0]    ret_q;
	logic [AW-1:0] init_idx_q;
	logic [AW-1:0] addr_q;
	logic [LW-1:0] tbl_rd_q;
	logic [DW-1:0] didx_q;
	logic [63:0]   dname_rd_q;
	logic [AW-1:0] dfirst_rd_q;

	logic [2:0]    cmd_q;
	logic [63:0]   name_q;
	logic [AW-1:0] blk_q;
	logic          blk_ok_q;
	logic          found_q;
	logic [DW-1:0] e_q;
	logic [AW-1:0] first_q;
	logic          freef_q;
	logic [DW-1:0] free_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] b_q;
	logic [AW-1:0] prev_q;
	logic [AW-1:0] lb_q;
	logic [CW-1:0] cnt_q;

	logic          res_valid_q;
	logic [2:0]    res_status_q;
	logic [6:0]    res_block_q;

	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	logic [LW-1:0] tbl_wdata;
	logic [LW-1:0] init_val;
	logic [AW-1:0] rd_link;
	logic          dmatch;

	// chain link of a table value: reserved or out of range ends the chain
	function automatic logic [AW-1:0] link_of(input logic [LW-1:0] v);
		if (v >= LW'(NUM_BLOCKS)) return '0;
		return v[AW-1:0];
	endfunction

	assign rd_link = link_of(tbl_rd_q);
	assign dmatch  = dvalid_q[didx_q] && (dname_rd_q == name_q);

	// reset image of one table entry
	always_comb begin
		if (init_idx_q == '0)
			init_val = (FIRST_DATA < NUM_BLOCKS) ? LW'(FIRST_DATA) : '0;
		else if (int'(init_idx_q) < FIRST_DATA)
			init_val = LW'(NUM_BLOCKS);
		else if (int'(init_idx_q) + 1 < NUM_BLOCKS)
			init_val = LW'(int'(init_idx_q) + 1);
		else
			init_val = '0;
	end

	// select the single table write of this cycle
	always_comb begin
		tbl_we    = 1'b0;
		tbl_waddr = '0;
		tbl_wdata = '0;
		unique case (state_q)
			S_INIT: begin
				tbl_we    = 1'b1;
				tbl_waddr = init_idx_q;
				tbl_wdata = init_val;
			end
			S_AW0: begin
				tbl_we    = 1'b1;
				tbl_wdata = {1'b0, lb_q};
			end
			S_AWH: begin
				tbl_we    = 1'b1;
				tbl_waddr = head_q;
			end
			S_AWT: begin
				tbl_we    = 1'b1;
				tbl_waddr = b_q;
				tbl_wdata = {1'b0, head_q};
			end
			S_DLNK: begin
				tbl_we    = (first_q != blk_q);
				tbl_waddr = prev_q;
				tbl_wdata = {1'b0, lb_q};
			end
			S_D0CHK: begin
				tbl_we    = 1'b1;
				tbl_waddr = blk_q;
				tbl_wdata = tbl_rd_q;
			end
			S_DHEAD: begin
				tbl_we    = 1'b1;
				tbl_wdata = {1'b0, blk_q};
			end
			default: begin
				tbl_we = 1'b0;
			end
		endcase
	end

	// table memory with registered read
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
		tbl_rd_q <= tbl_mem[addr_q];
	end

	// directory memories with registered read
	always_ff @(posedge clk) begin
		if (state_q == S_DISP && cmd_q == fcba_pkg::CMD_CREATE && !found_q && freef_q) begin
			dname_mem[free_q]  <= name_q;
			dfirst_mem[free_q] <= '0;
		end else if (state_q == S_AWH && first_q == '0) begin
			dfirst_mem[e_q] <= head_q;
		end else if (state_q == S_DLNK && first_q == blk_q) begin
			dfirst_mem[e_q] <= lb_q;
		end
		dname_rd_q  <= dname_mem[didx_q];
		dfirst_rd_q <= dfirst_mem[didx_q];
	end

	assign item_ready = (state_q == S_IDLE) && !res_valid_q;
	assign empty      = !res_valid_q;
	assign status     = res_status_q;
	assign block_out  = res_block_q;

	// sequence one command at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			ret_q        <= S_IDLE;
			init_idx_q   <= '0;
			dvalid_q     <= '0;
			res_valid_q  <= 1'b0;
			res_status_q <= fcba_pkg::ST_OK;
			res_block_q  <= '0;
			addr_q       <= '0;
			didx_q       <= '0;
			cmd_q        <= '0;
			name_q       <= '0;
			blk_q        <= '0;
			blk_ok_q     <= 1'b0;
			found_q      <= 1'b0;
			e_q          <= '0;
			first_q      <= '0;
			freef_q      <= 1'b0;
			free_q       <= '0;
			head_q       <= '0;
			b_q          <= '0;
			prev_q       <= '0;
			lb_q         <= '0;
			cnt_q        <= '0;
		end else begin
			if (pop && res_valid_q) res_valid_q <= 1'b0;
			unique case (state_q)
				S_INIT: begin
					init_idx_q <= init_idx_q + 1'b1;
					if (int'(init_idx_q) == NUM_BLOCKS - 1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid && !res_valid_q) begin
						cmd_q    <= item.cmd;
						name_q   <= item.file_name;
						blk_q    <= AW'(item.block_number);
						blk_ok_q <= item.blk_ok;
						found_q  <= 1'b0;
						freef_q  <= 1'b0;
						didx_q   <= '0;
						state_q  <= S_DRD;
					end
				end
				S_DRD: begin
					state_q <= S_DCHK;
				end
				S_DCHK: begin
					if (dmatch && !found_q) begin
						found_q <= 1'b1;
						e_q     <= didx_q;
						first_q <= dfirst_rd_q;
					end
					if (!dvalid_q[didx_q] && !freef_q) begin
						freef_q <= 1'b1;
						free_q  <= didx_q;
					end
					if (didx_q == DW'(ROOT_ENTRIES - 1)) begin
						state_q <= S_DISP;
					end else begin
						didx_q  <= didx_q + 1'b1;
						state_q <= S_DRD;
					end
				end
				S_DISP: begin
					unique case (cmd_q)
						fcba_pkg::CMD_CREATE: begin
							res_valid_q <= 1'b1;
							res_block_q <= '0;
							state_q     <= S_IDLE;
							if (found_q) begin
								res_status_q <= fcba_pkg::ST_EXISTS;
							end else if (!freef_q) begin
								res_status_q <= fcba_pkg::ST_DIR_FULL;
							end else begin
								res_status_q     <= fcba_pkg::ST_OK;
								dvalid_q[free_q] <= 1'b1;
							end
						end
						fcba_pkg::CMD_APPEND: begin
							addr_q  <= '0;
							ret_q   <= S_HCHK;
							state_q <= S_RD;
						end
						fcba_pkg::CMD_DELETE, fcba_pkg::CMD_NEXT, fcba_pkg::CMD_CHECK: begin
							if (!found_q || !blk_ok_q) begin
								res_valid_q  <= 1'b1;
								res_block_q  <= '0;
								res_status_q <= found_q ? fcba_pkg::ST_NOT_IN
								                        : fcba_pkg::ST_NO_FILE;
								state_q      <= S_IDLE;
							end else begin
								b_q     <= first_q;
								prev_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_OSTEP;
							end
						end
						fcba_pkg::CMD_REMOVE: begin
							res_valid_q <= 1'b1;
							res_block_q <= '0;
							state_q     <= S_IDLE;
							if (!found_q) begin
								res_status_q <= fcba_pkg::ST_NO_FILE;
							end else if (first_q != '0) begin
								res_status_q <= fcba_pkg::ST_NOT_EMPTY;
							end else begin
								res_status_q  <= fcba_pkg::ST_OK;
								dvalid_q[e_q] <= 1'b0;
							end
						end
						default: begin
							res_valid_q  <= 1'b1;
							res_block_q  <= '0;
							res_status_q <= fcba_pkg::ST_OK;
							state_q      <= S_IDLE;
						end
					endcase
				end
				S_RD: begin
					state_q <= ret_q;
				end
				S_HCHK: begin
					if (tbl_rd_q == '0 || tbl_rd_q >= LW'(NUM_BLOCKS)) begin
						res_valid_q  <= 1'b1;
						res_block_q  <= '0;
						res_status_q <= fcba_pkg::ST_NO_FREE;
						state_q      <= S_IDLE;
					end else if (!found_q) begin
						res_valid_q  <= 1'b1;
						res_block_q  <= '0;
						res_status_q <= fcba_pkg::ST_NO_FILE;
						state_q      <= S_IDLE;
					end else begin
						head_q  <= tbl_rd_q[AW-1:0];
						addr_q  <= tbl_rd_q[AW-1:0];
						ret_q   <= S_H2CHK;
						state_q <= S_RD;
					end
				end
				S_H2CHK: begin
					lb_q    <= rd_link;
					state_q <= S_AW0;
				end
				S_AW0: begin
					state_q <= S_AWH;
				end
				S_AWH: begin
					if (first_q == '0) begin
						res_valid_q  <= 1'b1;
						res_block_q  <= 7'(head_q);
						res_status_q <= fcba_pkg::ST_OK;
						state_q      <= S_IDLE;
					end else begin
						b_q     <= first_q;
						cnt_q   <= '0;
						addr_q  <= first_q;
						ret_q   <= S_WCHK;
						state_q <= S_RD;
					end
				end
				S_WCHK: begin
					if (cnt_q == CW'(NUM_BLOCKS) || rd_link == '0) begin
						state_q <= S_AWT;
					end else begin
						b_q     <= rd_link;
						cnt_q   <= cnt_q + 1'b1;
						addr_q  <= rd_link;
						state_q <= S_RD;
					end
				end
				S_AWT: begin
					res_valid_q  <= 1'b1;
					res_block_q  <= 7'(head_q);
					res_status_q <= fcba_pkg::ST_OK;
					state_q      <= S_IDLE;
				end
				S_OSTEP: begin
					if (cnt_q == CW'(NUM_BLOCKS) || b_q == '0) begin
						res_valid_q  <= 1'b1;
						res_block_q  <= '0;
						res_status_q <= fcba_pkg::ST_NOT_IN;
						state_q      <= S_IDLE;
					end else if (b_q == blk_q) begin
						if (cmd_q == fcba_pkg::CMD_CHECK) begin
							res_valid_q  <= 1'b1;
							res_block_q  <= '0;
							res_status_q <= fcba_pkg::ST_OK;
							state_q      <= S_IDLE;
						end else begin
							addr_q  <= blk_q;
							ret_q   <= S_LCHK;
							state_q <= S_RD;
						end
					end else begin
						addr_q  <= b_q;
						ret_q   <= S_OCHK;
						state_q <= S_RD;
					end
				end
				S_OCHK: begin
					prev_q  <= b_q;
					b_q     <= rd_link;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_OSTEP;
				end
				S_LCHK: begin
					lb_q <= rd_link;
					if (cmd_q == fcba_pkg::CMD_NEXT) begin
						res_valid_q  <= 1'b1;
						res_block_q  <= 7'(rd_link);
						res_status_q <= fcba_pkg::ST_OK;
						state_q      <= S_IDLE;
					end else begin
						state_q <= S_DLNK;
					end
				end
				S_DLNK: begin
					addr_q  <= '0;
					ret_q   <= S_D0CHK;
					state_q <= S_RD;
				end
				S_D0CHK: begin
					state_q <= S_DHEAD;
				end
				S_DHEAD: begin
					res_valid_q  <= 1'b1;
					res_block_q  <= '0;
					res_status_q <= fcba_pkg::ST_OK;
					state_q      <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a command runs only while the result slot is free
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && state_q != S_INIT) |-> !res_valid_q)
		else $error("command running while result still waits");
	// nothing enters during the table build
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INIT) |-> !item_ready)
		else $error("command taken during table build");
	// a successful append hands out a real block
	a_append_blk: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(res_valid_q) && cmd_q == fcba_pkg::CMD_APPEND
		 && res_status_q == fcba_pkg::ST_OK) |-> (res_block_q != 7'd0))
		else $error("append returned block zero");
`endif

endmodule

// ===== hw/rtl/fat_chain_block_allocator_top.sv =====
// Top level of the chained block allocator.
// After reset the block table is built one entry per cycle; up to two commands queue
// meanwhile, and full then stays high until the build ends. Each command then scans the
// directory entry by entry; append, delete, next and check then walk the block table link by
// link through its single registered read port, while create and remove need only the scan.
// Commands are carried out one at a time; two more queue at the input, and one result waits
// at the output until popped.
module fat_chain_block_allocator_top #(
	parameter int ROOT_ENTRIES = 10,
	parameter int TABLE_BLOCKS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [63:0] file_name,
	input  logic [6:0]  block_number,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [6:0]  block_out
);

	logic            item_valid;
	logic            item_ready;
	fcba_pkg::item_t item;

	// accept and classify
	fcba_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.cmd         (cmd),
		.file_name   (file_name),
		.block_number(block_number),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item)
	);

	// carry out
	fcba_back #(
		.ROOT_ENTRIES(ROOT_ENTRIES),
		.TABLE_BLOCKS(TABLE_BLOCKS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.empty     (empty),
		.pop       (pop),
		.status    (status),
		.block_out (block_out)
	);

endmodule

// ===== verif/fat_chain_block_allocator_checker.sv =====
// Checker that predicts allocator answers from the command stream and compares them.
module fat_chain_block_allocator_checker #(
	parameter int ROOT_ENTRIES = 10,
	parameter int TABLE_BLOCKS = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [2:0]  cmd,
	input  logic [63:0] file_name,
	input  logic [6:0]  block_number,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  status,
	input  logic [6:0]  block_out,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_BLOCKS = fcba_pkg::NUM_BLOCKS;
	localparam int RSV = NUM_BLOCKS;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] block_out;
	} answer_t;

	bit          dvalid [ROOT_ENTRIES];
	logic [63:0] dname  [ROOT_ENTRIES];
	int          dfirst [ROOT_ENTRIES];
	int          fat    [NUM_BLOCKS];
	answer_t     answers_q[$];

	assign pending = answers_q.size();

	function automatic int next_link(int b);
		if (b == 0 || b >= NUM_BLOCKS) return 0;
		if (fat[b] >= NUM_BLOCKS) return 0;
		return fat[b];
	endfunction

	function automatic int lookup(logic [63:0] name);
		for (int i = 0; i < ROOT_ENTRIES; i++)
			if (dvalid[i] && dname[i] == name) return i;
		return -1;
	endfunction

	function automatic bit chain_has(int first, int blk);
		int b;
		b = first;
		if (blk == 0 || blk >= NUM_BLOCKS) return 0;
		for (int s = 0; s < NUM_BLOCKS && b != 0; s++) begin
			if (b == blk) return 1;
			b = next_link(b);
		end
		return 0;
	endfunction

	task automatic build_table();
		for (int i = 0; i < ROOT_ENTRIES; i++) begin
			dvalid[i] = 0;
			dname[i]  = '0;
			dfirst[i] = 0;
		end
		for (int i = 1; i < NUM_BLOCKS; i++)
			fat[i] = (i < 2 + TABLE_BLOCKS) ? RSV : ((i + 1 < NUM_BLOCKS) ? i + 1 : 0);
		fat[0] = (2 + TABLE_BLOCKS < NUM_BLOCKS) ? 2 + TABLE_BLOCKS : 0;
	endtask

	// apply one command to the model and return its answer
	function automatic answer_t run_command(logic [2:0] c, logic [63:0] name, int blk);
		answer_t a;
		int e, head, b, p, n;
		a = '0;
		a.status = fcba_pkg::ST_OK;
		e = lookup(name);
		case (c)
			fcba_pkg::CMD_CREATE: begin
				if (e >= 0) a.status = fcba_pkg::ST_EXISTS;
				else begin
					a.status = fcba_pkg::ST_DIR_FULL;
					for (int i = 0; i < ROOT_ENTRIES; i++)
						if (!dvalid[i]) begin
							dvalid[i] = 1;
							dname[i]  = name;
							dfirst[i] = 0;
							a.status  = fcba_pkg::ST_OK;
							break;
						end
				end
			end
			fcba_pkg::CMD_APPEND: begin
				head = fat[0];
				if (head == 0 || head >= NUM_BLOCKS) a.status = fcba_pkg::ST_NO_FREE;
				else if (e < 0) a.status = fcba_pkg::ST_NO_FILE;
				else begin
					fat[0] = next_link(head);
					fat[head] = 0;
					if (dfirst[e] == 0 || dfirst[e] >= NUM_BLOCKS) dfirst[e] = head;
					else begin
						b = dfirst[e];
						for (int s = 0; s < NUM_BLOCKS && next_link(b) != 0; s++)
							b = next_link(b);
						fat[b] = head;
					end
					a.block_out = 7'(head);
				end
			end
			fcba_pkg::CMD_DELETE, fcba_pkg::CMD_NEXT, fcba_pkg::CMD_CHECK: begin
				if (e < 0) a.status = fcba_pkg::ST_NO_FILE;
				else if (!chain_has(dfirst[e], blk)) a.status = fcba_pkg::ST_NOT_IN;
				else if (c == fcba_pkg::CMD_DELETE) begin
					if (dfirst[e] == blk) dfirst[e] = next_link(blk);
					else begin
						p = dfirst[e];
						for (int s = 0; s < NUM_BLOCKS; s++) begin
							n = next_link(p);
							if (n == blk || n == 0) break;
							p = n;
						end
						if (p != 0 && p < NUM_BLOCKS) fat[p] = next_link(blk);
					end
					fat[blk] = fat[0];
					fat[0] = blk;
				end else if (c == fcba_pkg::CMD_NEXT) a.block_out = 7'(next_link(blk));
			end
			fcba_pkg::CMD_REMOVE: begin
				if (e < 0) a.status = fcba_pkg::ST_NO_FILE;
				else if (dfirst[e] != 0) a.status = fcba_pkg::ST_NOT_EMPTY;
				else begin
					dvalid[e] = 0;
					dfirst[e] = 0;
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	initial build_table();

	// predict on input transfer, compare on output transfer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (push && !full)
				answers_q = {answers_q, run_command(cmd, file_name, int'(block_number))};
			if (pop && !empty) begin
				if (answers_q.size() == 0) begin
					errors++;
					$display("%t: unexpected result status=%0d block_out=%0d",
						$realtime, status, block_out);
				end else begin
					want = answers_q.pop_front();
					if (want.status !== status) begin
						errors++;
						$display("%t: status expected %0d actual %0d",
							$realtime, want.status, status);
					end
					if (want.block_out !== block_out) begin
						errors++;
						$display("%t: block_out expected %0d actual %0d",
							$realtime, want.block_out, block_out);
					end
				end
			end
		end
	end

	initial errors = 0;
endmodule

// ===== verif/fat_chain_block_allocator_top_tb.sv =====
// Stimulus and verdict for the chained block allocator.
module fat_chain_block_allocator_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  NRAND = 1950;
	localparam longint LIMIT = 3000000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        push = 0;
	logic        full;
	logic [2:0]  cmd = '0;
	logic [63:0] file_name = '0;
	logic [6:0]  block_number = '0;
	logic        empty;
	logic        pop = 0;
	logic [2:0]  status;
	logic [6:0]  block_out;
	int          errors, pending;
	longint      cycles = 0;
	bit          calm = 0;
	logic [63:0] names [8];

	fat_chain_block_allocator_top DUT (.*);

	fat_chain_block_allocator_checker CHK (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	// stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// drain with random stalls
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (!calm && $urandom_range(0, 3) == 0) begin
				gap = $urandom_range(1, 9);
				pop <= 0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
		end
	end

	// present one command and hold it while the input reports full
	task automatic send(logic [2:0] c, logic [63:0] n, logic [6:0] b);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			push <= 0;
			repeat (gap) @(posedge clk);
		end
		push <= 1;
		cmd <= c;
		file_name <= n;
		block_number <= b;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic hold_off();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		logic [2:0] c;
		int r;
		names[0] = 64'h0;
		names[1] = 64'hFFFF_FFFF_FFFF_FFFF;
		for (int i = 2; i < 8; i++) names[i] = {$urandom, $urandom};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: errors on empty dir, fill dir, chains, removes
		send(fcba_pkg::CMD_APPEND, names[0], 7'd0);
		send(fcba_pkg::CMD_REMOVE, names[0], 7'd0);
		send(fcba_pkg::CMD_NEXT, names[1], 7'd9);
		for (int i = 0; i < 11; i++)
			send(fcba_pkg::CMD_CREATE, i < 2 ? names[i] : 64'h100 + i, 7'd0);
		send(fcba_pkg::CMD_CREATE, names[1], 7'd0);
		send(fcba_pkg::CMD_APPEND, names[1], 7'd0);
		send(fcba_pkg::CMD_APPEND, names[1], 7'd0);
		send(fcba_pkg::CMD_CHECK, names[1], 7'd10);
		send(fcba_pkg::CMD_NEXT, names[1], 7'd9);
		send(fcba_pkg::CMD_CHECK, names[1], 7'd0);
		send(fcba_pkg::CMD_CHECK, names[1], 7'd127);
		send(fcba_pkg::CMD_REMOVE, names[1], 7'd0);
		send(fcba_pkg::CMD_DELETE, names[1], 7'd9);
		send(fcba_pkg::CMD_DELETE, names[1], 7'd10);
		send(fcba_pkg::CMD_SPARE0, names[1], 7'd5);
		send(fcba_pkg::CMD_SPARE1, names[1], 7'd5);
		send(fcba_pkg::CMD_REMOVE, names[1], 7'd0);
		send(fcba_pkg::CMD_CHECK, names[0], 7'd9);
		hold_off();

		// random: mostly known names, appends favored to run the free list dry
		for (int k = 0; k < NRAND; k++) begin
			if (k == NRAND / 2) hold_off();
			if (k > NRAND * 9 / 10) calm = 1;
			r = $urandom_range(0, 99);
			if (r < 8) c = fcba_pkg::CMD_CREATE;
			else if (r < 40) c = fcba_pkg::CMD_APPEND;
			else if (r < 62) c = fcba_pkg::CMD_DELETE;
			else if (r < 74) c = fcba_pkg::CMD_NEXT;
			else if (r < 86) c = fcba_pkg::CMD_CHECK;
			else if (r < 97) c = fcba_pkg::CMD_REMOVE;
			else c = ($urandom_range(0, 1) == 0) ? fcba_pkg::CMD_SPARE0 : fcba_pkg::CMD_SPARE1;
			send(c, ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
				: (64'h100 + $urandom_range(0, 11)) ^ (($urandom_range(0, 3) == 0) ?
				names[$urandom_range(0, 7)] : 64'h0),
				($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(9, 40)));
		end
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== fat_chain_block_allocator_top.f =====
hw/rtl/fcba_pkg.sv
hw/rtl/fcba_front.sv
hw/rtl/fcba_back.sv
hw/rtl/fat_chain_block_allocator_top.sv
verif/fat_chain_block_allocator_checker.sv
verif/fat_chain_block_allocator_top_tb.sv
